>>> rtl/core/alr_pkg.sv
// Shared types and constants of the antialiased line rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package alr_pkg;

  // Fixed field widths of the channels
  localparam int COORD_W    = 12;
  localparam int COLOR_W    = 8;
  localparam int PIX_X_W    = 14;
  localparam int PIX_Y_W    = 13;
  localparam int PIX_C_W    = 9;
  localparam int WEIGHT_W   = 8;

  // Configuration registers
  localparam int IB_W       = 4;
  localparam int LVL_W      = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVELS    = 1'b1;

  localparam logic [IB_W-1:0]  IB_RESET  = 4'd8;
  localparam logic [IB_W-1:0]  IB_MAX    = 4'd8;
  localparam logic [LVL_W-1:0] LVL_RESET = 9'd256;

  // Input command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Line kinds
  localparam logic [2:0] MODE_HORIZ = 3'd0;
  localparam logic [2:0] MODE_VERT  = 3'd1;
  localparam logic [2:0] MODE_DIAG  = 3'd2;
  localparam logic [2:0] MODE_XMAJ  = 3'd3;
  localparam logic [2:0] MODE_YMAJ  = 3'd4;

  // Controller to datapath
  typedef struct packed {
    logic start;     // take a new line from the input beat
    logic step;      // advance the current line
    logic pair;      // emit the second pixel of a weighted pair
    logic div_step;  // one quotient bit of the error step
    logic load;      // capture a pixel into the output register
  } alr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic active;     // a line is in progress
    logic start_div;  // the line on the input needs an error step
    logic pair_next;  // the next step emits a weighted pair
    logic div_last;   // last quotient bit this cycle
  } alr_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/alr_if.sv
// Valid/ready channel interfaces for input beats and pixel beats.
`timescale 1ns / 1ps
`default_nettype none

interface alr_in_if;
  import alr_pkg::*;

  logic               valid;
  logic               ready;
  logic               command;
  logic [COORD_W-1:0] start_x;
  logic [COORD_W-1:0] start_y;
  logic [COORD_W-1:0] end_x;
  logic [COORD_W-1:0] end_y;
  logic [COLOR_W-1:0] base_color;

  modport source (
    output valid, command, start_x, start_y, end_x, end_y, base_color,
    input  ready
  );
  modport sink (
    input  valid, command, start_x, start_y, end_x, end_y, base_color,
    output ready
  );
endinterface

interface alr_out_if;
  import alr_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [PIX_X_W-1:0] pixel_x;
  logic        [PIX_Y_W-1:0] pixel_y;
  logic        [PIX_C_W-1:0] pixel_color;
  logic                      line_done;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, line_done,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, line_done,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/alr_ctrl.sv
// Controller: handshakes, output valid and the sequence of line commands.
`timescale 1ns / 1ps
`default_nettype none

module alr_ctrl import alr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_command,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output alr_cmd_t       cmd,
  input  wire alr_stat_t st
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_PAIR = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       in_acc;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    cmd          = '0;
    cmd.start    = in_acc && (in_command == CMD_START);
    cmd.step     = in_acc && (in_command == CMD_STEP);
    cmd.pair     = (state_r == ST_PAIR) && out_free;
    cmd.div_step = (state_r == ST_DIV);
    cmd.load     = cmd.start || (cmd.step && st.active) || cmd.pair;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.start && st.start_div) begin
          state_nxt = ST_DIV;
        end else if (cmd.step && st.pair_next) begin
          state_nxt = ST_PAIR;
        end
      end
      ST_DIV: begin
        if (st.div_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PAIR: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> rtl/core/alr_dp.sv
// Datapath: line state, error step divider, stepping and pixel output register.
`timescale 1ns / 1ps
`default_nettype none

module alr_dp import alr_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int ERROR_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire alr_cmd_t           cmd,
  output alr_stat_t               st,
  input  wire logic [COORD_W-1:0] start_x,
  input  wire logic [COORD_W-1:0] start_y,
  input  wire logic [COORD_W-1:0] end_x,
  input  wire logic [COORD_W-1:0] end_y,
  input  wire logic [COLOR_W-1:0] base_color,
  input  wire logic [IB_W-1:0]    intensity_bits,
  input  wire logic [LVL_W-1:0]   num_levels,
  output logic signed [PIX_X_W-1:0] pixel_x,
  output logic [PIX_Y_W-1:0]      pixel_y,
  output logic [PIX_C_W-1:0]      pixel_color,
  output logic                    line_done
);

  localparam int CB    = COORD_BITS;
  localparam int CW    = COORD_BITS + 1;
  localparam int EB    = ERROR_BITS;
  localparam int EXW   = (CB > COORD_W) ? CB : COORD_W;
  localparam int XW    = (CW > PIX_X_W) ? CW : PIX_X_W;
  localparam int YW    = (CW > PIX_Y_W) ? CW : PIX_Y_W;
  localparam int CNT_W = $clog2(ERROR_BITS + 1);
  localparam int SH_W  = $clog2(ERROR_BITS + 1);

  // Line state
  logic              active_r, active_nxt;
  logic [2:0]        mode_r, mode_nxt;
  logic [CW-1:0]     cur_x_r, cur_x_nxt;
  logic [CW-1:0]     cur_y_r, cur_y_nxt;
  logic [CB-1:0]     fin_x_r, fin_x_nxt;
  logic [CB-1:0]     fin_y_r, fin_y_nxt;
  logic              neg_r, neg_nxt;
  logic [CB-1:0]     steps_r, steps_nxt;
  logic [EB-1:0]     acc_r, acc_nxt;
  logic [EB-1:0]     adj_r, adj_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;
  // Divider
  logic [CB-1:0]     den_r, den_nxt;
  logic [CB-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  // Output register
  logic [PIX_X_W-1:0] px_r, px_nxt;
  logic [PIX_Y_W-1:0] py_r, py_nxt;
  logic [PIX_C_W-1:0] pc_r, pc_nxt;
  logic               pd_r, pd_nxt;

  // Start decode
  logic [EXW-1:0] sx_e, sy_e, ex_e, ey_e;
  logic [CB-1:0]  x0, y0, x1, y1, ax, ay, bx, by;
  logic [CB-1:0]  dx, dy, major, minor, s_steps;
  logic           s_neg, s_point, s_wtd;
  logic [2:0]     s_mode;

  assign sx_e = EXW'(start_x);
  assign sy_e = EXW'(start_y);
  assign ex_e = EXW'(end_x);
  assign ey_e = EXW'(end_y);
  assign x0   = sx_e[CB-1:0];
  assign y0   = sy_e[CB-1:0];
  assign x1   = ex_e[CB-1:0];
  assign y1   = ey_e[CB-1:0];

  always_comb begin
    // run the line top to bottom
    if (y0 > y1) begin
      ax = x1; ay = y1; bx = x0; by = y0;
    end else begin
      ax = x0; ay = y0; bx = x1; by = y1;
    end
    s_neg   = bx < ax;
    dx      = s_neg ? (ax - bx) : (bx - ax);
    dy      = by - ay;
    s_point = (dx == '0) && (dy == '0);
    s_wtd   = (dx != '0) && (dy != '0) && (dx != dy);
    major   = (dy > dx) ? dy : dx;
    minor   = (dy > dx) ? dx : dy;
    if (dy == '0) begin
      s_mode  = MODE_HORIZ;
      s_steps = dx;
    end else if (dx == '0) begin
      s_mode  = MODE_VERT;
      s_steps = dy;
    end else if (dx == dy) begin
      s_mode  = MODE_DIAG;
      s_steps = dy;
    end else begin
      s_mode  = (dy > dx) ? MODE_YMAJ : MODE_XMAJ;
      s_steps = major - CB'(1);
    end
  end

  // Stepping
  logic          wtd;
  logic [CW-1:0] x_dir, x_adv, y_adv;
  logic [CB-1:0] steps_dec;
  logic [EB-1:0] acc_sum;
  logic          turn;
  logic [CW-1:0] u_x, u_y, w_x, w_y;

  assign wtd       = (mode_r inside {MODE_XMAJ, MODE_YMAJ});
  assign x_dir     = neg_r ? '1 : CW'(1);
  assign x_adv     = cur_x_r + x_dir;
  assign y_adv     = cur_y_r + CW'(1);
  assign steps_dec = (steps_r != '0) ? (steps_r - CB'(1)) : '0;
  assign acc_sum   = acc_r + adj_r;
  // an unchanged accumulator counts as a turnover
  assign turn      = acc_sum <= acc_r;

  always_comb begin
    u_x = (mode_r == MODE_VERT) ? cur_x_r : x_adv;
    u_y = (mode_r == MODE_HORIZ) ? cur_y_r : y_adv;
    if (mode_r == MODE_YMAJ) begin
      w_x = turn ? x_adv : cur_x_r;
      w_y = y_adv;
    end else begin
      w_x = x_adv;
      w_y = turn ? y_adv : cur_y_r;
    end
  end

  // Weighting from the top bits of the accumulator
  logic [IB_W-1:0]    ib;
  logic [SH_W-1:0]    shamt;
  logic [EB-1:0]      acc_src, acc_sh;
  logic [WEIGHT_W-1:0] wgt;
  logic [PIX_C_W-1:0] cmask, col_w, col_c, col_b;

  assign ib      = (intensity_bits > IB_MAX) ? IB_MAX : intensity_bits;
  assign shamt   = SH_W'(ERROR_BITS) - SH_W'(ib);
  assign acc_src = cmd.pair ? acc_r : acc_sum;
  assign acc_sh  = acc_src >> shamt;
  assign wgt     = acc_sh[WEIGHT_W-1:0];
  assign cmask   = num_levels - LVL_W'(1);
  assign col_b   = PIX_C_W'(color_r);
  assign col_w   = col_b + PIX_C_W'(wgt);
  assign col_c   = col_b + (PIX_C_W'(wgt) ^ cmask);

  // Divider: one quotient bit a cycle
  logic [CB:0] div_sh;
  logic        div_ge;

  assign div_sh = {rem_r, 1'b0};
  assign div_ge = div_sh >= {1'b0, den_r};

  // Pixel candidates widened before trimming to the output fields
  logic [XW-1:0] ox;
  logic [YW-1:0] oy;

  always_comb begin
    active_nxt = active_r;
    mode_nxt   = mode_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    fin_x_nxt  = fin_x_r;
    fin_y_nxt  = fin_y_r;
    neg_nxt    = neg_r;
    steps_nxt  = steps_r;
    acc_nxt    = acc_r;
    adj_nxt    = adj_r;
    color_nxt  = color_r;
    den_nxt    = den_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    ox         = XW'(cur_x_r);
    oy         = YW'(cur_y_r);
    pc_nxt     = col_b;
    pd_nxt     = 1'b0;

    if (cmd.start) begin
      active_nxt = !s_point;
      mode_nxt   = s_mode;
      cur_x_nxt  = CW'(ax);
      cur_y_nxt  = CW'(ay);
      fin_x_nxt  = bx;
      fin_y_nxt  = by;
      neg_nxt    = s_neg;
      steps_nxt  = s_steps;
      acc_nxt    = '0;
      adj_nxt    = '0;
      color_nxt  = base_color;
      den_nxt    = major;
      rem_nxt    = minor;
      cnt_nxt    = s_wtd ? CNT_W'(ERROR_BITS) : '0;
      ox         = XW'(ax);
      oy         = YW'(ay);
      pc_nxt     = PIX_C_W'(base_color);
      pd_nxt     = s_point;
    end else if (cmd.step && active_r) begin
      if (!wtd) begin
        cur_x_nxt  = u_x;
        cur_y_nxt  = u_y;
        steps_nxt  = steps_dec;
        active_nxt = steps_dec != '0;
        ox         = XW'(u_x);
        oy         = YW'(u_y);
        pd_nxt     = steps_dec == '0;
      end else if (steps_r == '0) begin
        // exact final endpoint
        active_nxt = 1'b0;
        ox         = XW'(fin_x_r);
        oy         = YW'(fin_y_r);
        pd_nxt     = 1'b1;
      end else begin
        steps_nxt = steps_dec;
        acc_nxt   = acc_sum;
        cur_x_nxt = w_x;
        cur_y_nxt = w_y;
        ox        = XW'(w_x);
        oy        = YW'(w_y);
        pc_nxt    = col_w;
      end
    end else if (cmd.pair) begin
      // neighbor across the minor axis, complement weighting
      if (mode_r == MODE_YMAJ) begin
        ox = XW'(cur_x_r) + (neg_r ? '1 : XW'(1));
      end else begin
        oy = YW'(cur_y_r) + YW'(1);
      end
      pc_nxt = col_c;
    end else if (cmd.div_step) begin
      rem_nxt = div_ge ? CB'(div_sh - {1'b0, den_r}) : CB'(div_sh);
      adj_nxt = {adj_r[EB-2:0], div_ge};
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  assign px_nxt = ox[PIX_X_W-1:0];
  assign py_nxt = oy[PIX_Y_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    cur_x_r <= cur_x_nxt;
    cur_y_r <= cur_y_nxt;
    fin_x_r <= fin_x_nxt;
    fin_y_r <= fin_y_nxt;
    neg_r   <= neg_nxt;
    steps_r <= steps_nxt;
    acc_r   <= acc_nxt;
    adj_r   <= adj_nxt;
    color_r <= color_nxt;
    den_r   <= den_nxt;
    rem_r   <= rem_nxt;
    if (cmd.load) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
      pc_r <= pc_nxt;
      pd_r <= pd_nxt;
    end
  end

  always_comb begin
    st           = '0;
    st.active    = active_r;
    st.start_div = s_wtd;
    st.pair_next = active_r && wtd && (steps_r != '0);
    st.div_last  = cnt_r == CNT_W'(1);
  end

  assign pixel_x     = $signed(px_r);
  assign pixel_y     = py_r;
  assign pixel_color = pc_r;
  assign line_done   = pd_r;

endmodule

`default_nettype wire

>>> rtl/core/antialiased_line_rasterizer_top.sv
// Top level of the antialiased line rasterizer: configuration, controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Wu antialiased line generator. A start beat (command 0) orders the endpoints top to
// bottom and emits the first pixel in the cycle after it is taken; X-major and Y-major
// lines then run an iterative restoring divider (one quotient bit per cycle) to form
// the error step, during which no input beat is taken. A step beat (command 1) emits
// one pixel on straight lines and on the final endpoint; on weighted lines it emits a
// pixel pair through the single output register, taking no input beat until the second
// is loaded. A step while no line is active is taken and emits nothing. The output
// register lets a new beat in while it drains in the same cycle. The user must write
// intensity_bits and num_levels via the cfg port only while idle; it is not enforced.
module antialiased_line_rasterizer_top import alr_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int ERROR_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  alr_in_if.sink                     in_ch,
  alr_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [IB_W-1:0]  intensity_r;
  logic [LVL_W-1:0] levels_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intensity_r <= IB_RESET;
      levels_r    <= LVL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INTENSITY: intensity_r <= cfg_data[IB_W-1:0];
        CFG_LEVELS:    levels_r    <= cfg_data[LVL_W-1:0];
        default:       ;
      endcase
    end
  end

  alr_cmd_t  cmd;
  alr_stat_t st;

  alr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .cmd        (cmd),
    .st         (st)
  );

  alr_dp #(
    .COORD_BITS (COORD_BITS),
    .ERROR_BITS (ERROR_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .start_x        (in_ch.start_x),
    .start_y        (in_ch.start_y),
    .end_x          (in_ch.end_x),
    .end_y          (in_ch.end_y),
    .base_color     (in_ch.base_color),
    .intensity_bits (intensity_r),
    .num_levels     (levels_r),
    .pixel_x        (out_ch.pixel_x),
    .pixel_y        (out_ch.pixel_y),
    .pixel_color    (out_ch.pixel_color),
    .line_done      (out_ch.line_done)
  );

endmodule

`default_nettype wire

>>> rtl/core/alr_checker.sv
// Port-level assertions for the antialiased line rasterizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module alr_checker import alr_pkg::*; (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic signed [PIX_X_W-1:0] out_pixel_x,
  input wire logic        [PIX_Y_W-1:0] out_pixel_y,
  input wire logic        [PIX_C_W-1:0] out_pixel_color,
  input wire logic                      out_line_done
);

  // A stalled pixel beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("pixel beat dropped while stalled");

  // A stalled pixel beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pixel_x) && $stable(out_pixel_y)
                                && $stable(out_pixel_color) && $stable(out_line_done))
    else $error("pixel payload changed while stalled");

  // No input beat is taken while a pixel waits on a stalled output.
  a_no_in_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // A fresh pixel beat always follows an accepted input beat.
  a_out_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("pixel beat without an input beat");

endmodule

bind antialiased_line_rasterizer_top alr_checker u_alr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_pixel_x     (out_ch.pixel_x),
  .out_pixel_y     (out_ch.pixel_y),
  .out_pixel_color (out_ch.pixel_color),
  .out_line_done   (out_ch.line_done)
);

`default_nettype wire

>>> sim/alr_pixel_checker.sv
// Pixel checker: predicts the pixel beats of each input beat and compares them.
`timescale 1ns / 1ps

module alr_pixel_checker import alr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  alr_in_if                     in_mon,
  alr_out_if                    out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);

  localparam int ERR_W      = 16;

  typedef struct packed {
    logic signed [PIX_X_W-1:0] x;
    logic        [PIX_Y_W-1:0] y;
    logic        [PIX_C_W-1:0] color;
    logic                      done;
  } pixel_t;

  pixel_t want_pixels [$];
  pixel_t want;
  int     fail_cnt = 0;
  int     pend_r   = 0;

  // Configuration copy
  logic [IB_W-1:0]  cfg_ib;
  logic [LVL_W-1:0] cfg_lvl;

  // Line state
  logic             ln_active;
  logic [2:0]       ln_mode;
  logic [12:0]      ln_x;
  logic [12:0]      ln_y;
  logic [11:0]      ln_end_x;
  logic [11:0]      ln_end_y;
  logic             ln_back;   // x runs toward smaller values
  logic [12:0]      ln_left;
  logic [ERR_W-1:0] ln_acc;
  logic [ERR_W-1:0] ln_adj;
  logic [7:0]       ln_color;

  assign mismatches  = fail_cnt;
  assign outstanding = pend_r;

  task automatic flag(input string what);
    fail_cnt++;
    $display("%0t ns pixel check: %s", $time, what);
  endtask

  function automatic pixel_t pix(input logic [13:0] x, input logic [12:0] y,
                                 input logic [8:0] c, input logic d);
    pixel_t p;
    p.x     = x;
    p.y     = y;
    p.color = c;
    p.done  = d;
    return p;
  endfunction

  // append a predicted pixel beat at the tail
  task automatic queue_pixel(input pixel_t p);
    want_pixels.insert(want_pixels.size(), p);
  endtask

  task automatic begin_line(input logic [11:0] sx, input logic [11:0] sy,
                            input logic [11:0] ex, input logic [11:0] ey,
                            input logic [7:0] bc);
    logic [11:0] x0, y0, x1, y1, dx, dy, major, minor;
    logic [31:0] quot;
    x0 = sx;
    y0 = sy;
    x1 = ex;
    y1 = ey;
    // run top to bottom
    if (y0 > y1) begin
      y0 = ey;
      y1 = sy;
      x0 = ex;
      x1 = sx;
    end
    ln_color = bc;
    ln_x     = {1'b0, x0};
    ln_y     = {1'b0, y0};
    ln_end_x = x1;
    ln_end_y = y1;
    ln_back  = x1 < x0;
    dx       = ln_back ? x0 - x1 : x1 - x0;
    dy       = y1 - y0;
    ln_acc   = '0;
    ln_adj   = '0;
    if (dx == 0 && dy == 0) begin
      ln_active = 1'b0;
      ln_mode   = MODE_HORIZ;
      ln_left   = '0;
      queue_pixel(pix({2'b0, x0}, {1'b0, y0}, {1'b0, bc}, 1'b1));
    end else begin
      queue_pixel(pix({2'b0, x0}, {1'b0, y0}, {1'b0, bc}, 1'b0));
      ln_active = 1'b1;
      if (dy == 0) begin
        ln_mode = MODE_HORIZ;
        ln_left = {1'b0, dx};
      end else if (dx == 0) begin
        ln_mode = MODE_VERT;
        ln_left = {1'b0, dy};
      end else if (dx == dy) begin
        ln_mode = MODE_DIAG;
        ln_left = {1'b0, dy};
      end else begin
        ln_mode = (dy > dx) ? MODE_YMAJ : MODE_XMAJ;
        major   = (dy > dx) ? dy : dx;
        minor   = (dy > dx) ? dx : dy;
        quot    = ({20'd0, minor} << ERR_W) / {20'd0, major};
        ln_adj  = quot[ERR_W-1:0];
        ln_left = {1'b0, major} - 13'd1;
      end
    end
  endtask

  task automatic advance_line();
    logic [12:0]      dir13;
    logic [13:0]      dir14;
    logic [ERR_W-1:0] prev;
    logic [ERR_W-1:0] top_bits;
    logic [3:0]       ib;
    logic [8:0]       w;
    logic [8:0]       cmask;
    logic [8:0]       c0;
    logic [8:0]       c1;
    if (!ln_active) return;
    dir13 = ln_back ? 13'h1FFF : 13'd1;
    dir14 = ln_back ? 14'h3FFF : 14'd1;
    if (ln_mode == MODE_HORIZ || ln_mode == MODE_VERT || ln_mode == MODE_DIAG) begin
      if (ln_mode != MODE_VERT) ln_x = ln_x + dir13;
      if (ln_mode != MODE_HORIZ) ln_y = ln_y + 13'd1;
      if (ln_left != 0) ln_left = ln_left - 13'd1;
      if (ln_left == 0) ln_active = 1'b0;
      queue_pixel(pix({1'b0, ln_x}, ln_y, {1'b0, ln_color}, ln_left == 0));
    end else if (ln_left == 0) begin
      // finish on the exact endpoint
      ln_active = 1'b0;
      queue_pixel(pix({2'b0, ln_end_x}, {1'b0, ln_end_y}, {1'b0, ln_color}, 1'b1));
    end else begin
      ln_left = ln_left - 13'd1;
      prev    = ln_acc;
      ln_acc  = ln_acc + ln_adj;
      // a non-increasing accumulator is a turnover: advance the minor axis
      if (ln_mode == MODE_YMAJ) begin
        if (ln_acc <= prev) ln_x = ln_x + dir13;
        ln_y = ln_y + 13'd1;
      end else begin
        if (ln_acc <= prev) ln_y = ln_y + 13'd1;
        ln_x = ln_x + dir13;
      end
      ib       = (cfg_ib > IB_MAX) ? IB_MAX : cfg_ib;
      top_bits = ln_acc >> (ERR_W - ib);
      w        = {1'b0, top_bits[7:0]};
      cmask    = cfg_lvl - 9'd1;
      c0       = {1'b0, ln_color} + w;
      c1       = {1'b0, ln_color} + (w ^ cmask);
      queue_pixel(pix({1'b0, ln_x}, ln_y, c0, 1'b0));
      if (ln_mode == MODE_YMAJ)
        queue_pixel(pix({1'b0, ln_x} + dir14, ln_y, c1, 1'b0));
      else
        queue_pixel(pix({1'b0, ln_x}, ln_y + 13'd1, c1, 1'b0));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_ib    = IB_RESET;
      cfg_lvl   = LVL_RESET;
      ln_active = 1'b0;
      ln_mode   = MODE_HORIZ;
      ln_x      = '0;
      ln_y      = '0;
      ln_end_x  = '0;
      ln_end_y  = '0;
      ln_back   = 1'b0;
      ln_left   = '0;
      ln_acc    = '0;
      ln_adj    = '0;
      ln_color  = '0;
      want_pixels.delete();
      pend_r <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_INTENSITY) cfg_ib = cfg_data[IB_W-1:0];
        else if (cfg_index == CFG_LEVELS) cfg_lvl = cfg_data[LVL_W-1:0];
      end
      // drain before predicting: a pixel beat never belongs to a beat taken this edge
      if (out_mon.valid && out_mon.ready) begin
        if (want_pixels.size() == 0) begin
          flag($sformatf("unexpected pixel x=%0d y=%0d color=%0d done=%0b",
                         out_mon.pixel_x, out_mon.pixel_y, out_mon.pixel_color,
                         out_mon.line_done));
        end else begin
          want = want_pixels.pop_front();
          if (out_mon.pixel_x !== want.x)
            flag($sformatf("pixel_x %0d, want %0d", out_mon.pixel_x, $signed(want.x)));
          if (out_mon.pixel_y !== want.y)
            flag($sformatf("pixel_y %0d, want %0d", out_mon.pixel_y, want.y));
          if (out_mon.pixel_color !== want.color)
            flag($sformatf("pixel_color %0d, want %0d", out_mon.pixel_color, want.color));
          if (out_mon.line_done !== want.done)
            flag($sformatf("line_done %0b, want %0b", out_mon.line_done, want.done));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.command == CMD_START)
          begin_line(in_mon.start_x, in_mon.start_y, in_mon.end_x, in_mon.end_y,
                     in_mon.base_color);
        else
          advance_line();
      end
      pend_r <= want_pixels.size();
    end
  end

endmodule

>>> sim/testbench.sv
// Testbench top: clock, reset, line and step beats, pixel sink pacing and verdict.
`timescale 1ns / 1ps

module testbench;
  import alr_pkg::*;

  localparam int SETTLE      = 40;    // covers the divider and the output register
  localparam int HOLD_CYCLES = 150;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_BEATS = 130;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    outstanding;
  int                    beats_sent = 0;
  logic                  tx_burst = 1'b0;

  alr_in_if  in_ch ();
  alr_out_if out_ch ();

  antialiased_line_rasterizer_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  alr_pixel_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [11:0] rnd12();
    return 12'($urandom);
  endfunction

  function automatic logic [11:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 12'd0;
      1: return 12'd4095;
      default: return rnd12();
    endcase
  endfunction

  // offset by d either way, staying inside the coordinate range
  function automatic logic [11:0] nearby(input logic [11:0] c, input int d);
    if ($urandom_range(0, 1) == 1) begin
      if (int'(c) + d <= 4095) return c + 12'(d);
      return c - 12'(d);
    end
    if (int'(c) >= d) return c - 12'(d);
    return c + 12'(d);
  endfunction

  task automatic send_item(input logic cmd, input logic [11:0] sx, input logic [11:0] sy,
                           input logic [11:0] ex, input logic [11:0] ey,
                           input logic [7:0] bc);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 4);
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.start_x    <= sx;
    in_ch.start_y    <= sy;
    in_ch.end_x      <= ex;
    in_ch.end_y      <= ey;
    in_ch.base_color <= bc;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
  endtask

  // start a line, then issue a number of steps with junk in the unused fields
  task automatic drive_line(input logic [11:0] sx, input logic [11:0] sy,
                            input logic [11:0] ex, input logic [11:0] ey,
                            input logic [7:0] bc, input int steps);
    send_item(CMD_START, sx, sy, ex, ey, bc);
    repeat (steps) send_item(CMD_STEP, rnd12(), rnd12(), rnd12(), rnd12(), 8'($urandom));
  endtask

  task automatic write_cfg(input logic [IB_W-1:0] ib, input logic [LVL_W-1:0] lvl);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_INTENSITY;
    cfg_data  <= {5'($urandom), ib};
    @(posedge clk);
    cfg_index <= CFG_LEVELS;
    cfg_data  <= lvl;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_episode();
    int          kind;
    int          shape;
    int          dx;
    int          dy;
    int          n;
    logic [11:0] x0;
    logic [11:0] y0;
    kind = $urandom_range(0, 19);
    if (kind >= 18) begin
      // noise: any command, any fields
      send_item(1'($urandom), rnd12(), rnd12(), rnd12(), rnd12(), 8'($urandom));
    end else if (kind >= 16) begin
      // long line with a full-size divide, abandoned early
      drive_line(pick_coord(), pick_coord(), pick_coord(), pick_coord(), 8'($urandom),
                 $urandom_range(0, 8));
    end else begin
      shape = $urandom_range(0, 7);
      dx    = $urandom_range(1, 12);
      dy    = $urandom_range(1, 12);
      case (shape)
        0: begin
          dx = 0;
          dy = 0;
        end
        1: dy = 0;
        2: dx = 0;
        3: dy = dx;
        default: ;
      endcase
      x0 = pick_coord();
      y0 = pick_coord();
      n  = (dx > dy) ? dx : dy;
      if (kind >= 14 && n > 0) n = $urandom_range(0, n - 1);
      else if ($urandom_range(0, 3) == 0) n++;   // one more step lands while idle
      drive_line(x0, y0, nearby(x0, dx), nearby(y0, dy), 8'($urandom), n);
    end
  endtask

  initial begin : stimulus
    logic [IB_W-1:0]  ib;
    logic [LVL_W-1:0] lvl;
    int               quota;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.command    <= CMD_START;
    in_ch.start_x    <= '0;
    in_ch.start_y    <= '0;
    in_ch.end_x      <= '0;
    in_ch.end_y      <= '0;
    in_ch.base_color <= '0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_INTENSITY;
    cfg_data         <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed lines under the reset configuration
    drive_line(12'd0, 12'd0, 12'd0, 12'd0, 8'd0, 1);           // single point, idle step
    drive_line(12'd4095, 12'd4095, 12'd4095, 12'd4095, 8'd255, 0);
    drive_line(12'd4095, 12'd0, 12'd4093, 12'd0, 8'd255, 2);    // horizontal, leftward
    drive_line(12'd0, 12'd4095, 12'd0, 12'd4093, 8'h5A, 2);     // vertical, swapped
    drive_line(12'd4095, 12'd4093, 12'd4093, 12'd4095, 8'hA5, 2); // diagonal, leftward
    drive_line(12'd0, 12'd4094, 12'd3, 12'd4095, 8'd200, 3);    // x-major
    drive_line(12'd0, 12'd3, 12'd1, 12'd0, 8'd255, 4);          // y-major, swapped, idle step
    drive_line(12'd0, 12'd0, 12'd4095, 12'd4094, 8'h0F, 2);     // long x-major
    drive_line(12'd5, 12'd7, 12'd5, 12'd7, 8'hF0, 0);           // restart mid-line

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin ib = 4'd8;  lvl = 9'd256; end
        1: begin ib = 4'd0;  lvl = 9'd0;   end
        2: begin ib = 4'd15; lvl = 9'd511; end
        3: begin ib = 4'd1;  lvl = 9'd2;   end
        4: begin ib = 4'd4;  lvl = 9'd16;  end
        5: begin ib = 4'd9;  lvl = 9'd300; end
        6: begin ib = 4'd8;  lvl = 9'd256; end
        default: begin
          ib  = 4'($urandom);
          lvl = 9'($urandom);
        end
      endcase
      write_cfg(ib, lvl);
      quota = beats_sent + PHASE_BEATS;
      while (beats_sent < quota) run_episode();
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // pixel sink: random back-pressure, bursts, and a long hold now and then
  initial begin : pixel_sink
    int   gap;
    int   taken;
    logic burst;
    taken = 0;
    burst = 1'b0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken > 0 && taken % 400 == 0) gap = HOLD_CYCLES;
      else gap = burst ? 0 : $urandom_range(0, 4);
      if ($urandom_range(0, 39) == 0) burst = !burst;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
